// File: sv/dep_pkg.sv
// Package for the double-ended priority queue.
// Holds the payload widths, the request and status codes, and the per-cell control type.
// No dependencies.
package dep_pkg;

    localparam int DEP_CAPACITY = 16;
    localparam int DEP_VAL_W    = 32;
    localparam int DEP_OCC_W    = 5;

    // Request codes; the fourth code of the field does nothing.
    typedef enum logic [1:0] {
        MODE_ADD     = 2'd0,
        MODE_POP_MAX = 2'd1,
        MODE_POP_MIN = 2'd2
    } t_mode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Control that the top level hands to every cell of the chain.
    typedef struct packed {
        logic do_add;
        logic do_min;
        logic occupied;
    } t_cell_ctl;

endpackage

// File: sv/dep_in_if.sv
// Request channel of the double-ended priority queue.
// Depends on dep_pkg for the payload widths.
interface dep_in_if
    import dep_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic signed [DEP_VAL_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// File: sv/dep_out_if.sv
// Result channel of the double-ended priority queue.
// Depends on dep_pkg for the payload widths.
interface dep_out_if
    import dep_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [DEP_VAL_W-1:0] removed_value;
    logic [1:0]                  status;
    logic [DEP_OCC_W-1:0]        occupancy;

    modport source (output valid, output removed_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input removed_value, input status, input occupancy,
                    output ready);
endinterface

// File: sv/dep_cell.sv
// One cell of the sorted chain: holds one value and trades it with its neighbors.
// Depends on dep_pkg.
module dep_cell
    import dep_pkg::*;
(
    input  logic                        i_clk,
    input  t_cell_ctl                   i_ctl,
    input  logic signed [DEP_VAL_W-1:0] i_val,
    input  logic signed [DEP_VAL_W-1:0] i_left_val,
    input  logic                        i_left_gt,
    input  logic signed [DEP_VAL_W-1:0] i_right_val,
    output logic signed [DEP_VAL_W-1:0] o_val,
    output logic                        o_gt
);

    logic signed [DEP_VAL_W-1:0] r_val;
    logic signed [DEP_VAL_W-1:0] n_val;

    // A free cell, or one holding a value larger than the new one, must move up.
    assign o_gt  = !i_ctl.occupied || (i_val < r_val);
    assign o_val = r_val;

    // On an add the cell takes its left neighbor's value if that one moves too,
    // otherwise the new value lands here; on a minimum removal all shift down.
    always_comb begin
        n_val = r_val;
        if (i_ctl.do_add) begin
            if (o_gt) begin
                n_val = i_left_gt ? i_left_val : i_val;
            end
        end else if (i_ctl.do_min) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// File: sv/double_ended_priority_queue.sv
// Double-ended priority queue built as a sorted chain of cells, smallest at cell 0.
// Depends on dep_pkg, dep_in_if, dep_out_if and dep_cell.
//
// Usage:
//   i_req carries one request: mode (add, remove maximum, remove minimum) and a value.
//   o_rsp returns exactly one result per request: the removed value (zero unless a
//   removal succeeded), a status (ok, empty on removal, full on add) and the number
//   of values held afterwards, low five bits.
//   Every cell compares the incoming value with its own in parallel and shifts in
//   one step, so a request is done in the cycle it is accepted. The result is loaded
//   into the output register as the request is accepted, and a new request is taken
//   every cycle while the receiver keeps up: throughput is one request per cycle.
//   The maximum is read from the cell just below the count through an OR tree over
//   the cells; that read and the compare across the row set the cycle time.
//   When the receiver stalls, the result holds in the output register and ready
//   drops until it is taken, so no request is lost.
//   Reset empties the queue (count to zero) and clears the output valid; cell
//   contents are left as they are, since only cells below the count are read.
//   An add to a full queue is dropped with the full status; a removal from an
//   empty queue returns the empty status; the unused mode code changes nothing.
module double_ended_priority_queue
    import dep_pkg::*;
#(
    parameter int CAPACITY = DEP_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dep_in_if.sink    i_req,
    dep_out_if.source o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic                        r_out_valid;
    logic signed [DEP_VAL_W-1:0] r_removed;
    logic signed [DEP_VAL_W-1:0] n_removed;
    logic [1:0]                  r_status;
    logic [1:0]                  n_status;
    logic [DEP_OCC_W-1:0]        r_occ;

    logic                        w_accept;
    logic                        w_full;
    logic                        w_empty;
    logic                        w_do_add;
    logic                        w_do_min;
    logic signed [DEP_VAL_W-1:0] w_max;
    logic signed [DEP_VAL_W-1:0] w_cell_val [CAPACITY];
    logic                        w_cell_gt  [CAPACITY];
    logic                        w_last     [CAPACITY];

    // Handshake: take a request whenever the output register is free or being emptied.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_do_add    = w_accept && (i_req.mode == MODE_ADD) && !w_full;
    assign w_do_min    = w_accept && (i_req.mode == MODE_POP_MIN) && !w_empty;

    // The row of cells.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_cell_ctl                   w_ctl;
        logic signed [DEP_VAL_W-1:0] w_left_val;
        logic                        w_left_gt;
        logic signed [DEP_VAL_W-1:0] w_right_val;

        assign w_ctl.do_add   = w_do_add;
        assign w_ctl.do_min   = w_do_min;
        assign w_ctl.occupied = (CNT_W'(gi) < r_count);
        assign w_last[gi]     = (CNT_W'(gi + 1) == r_count);

        if (gi == 0) begin : g_first
            assign w_left_val = i_req.value;
            assign w_left_gt  = 1'b0;
        end else begin : g_mid
            assign w_left_val = w_cell_val[gi-1];
            assign w_left_gt  = w_cell_gt[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_end
            assign w_right_val = w_cell_val[gi];
        end else begin : g_inner
            assign w_right_val = w_cell_val[gi+1];
        end

        dep_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_val       (i_req.value),
            .i_left_val  (w_left_val),
            .i_left_gt   (w_left_gt),
            .i_right_val (w_right_val),
            .o_val       (w_cell_val[gi]),
            .o_gt        (w_cell_gt[gi])
        );
    end

    // The largest value sits in the topmost occupied cell.
    always_comb begin
        w_max = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_max = w_max | (w_cell_val[i] & {DEP_VAL_W{w_last[i]}});
        end
    end

    // Count update and result for the accepted request.
    always_comb begin
        n_count   = r_count;
        n_removed = '0;
        n_status  = ST_OK;
        case (i_req.mode)
            MODE_ADD: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            MODE_POP_MAX, MODE_POP_MIN: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count   = r_count - 1'b1;
                    n_removed = (i_req.mode == MODE_POP_MAX) ? w_max : w_cell_val[0];
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_removed <= n_removed;
            r_status  <= n_status;
            r_occ     <= DEP_OCC_W'(n_count);
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.removed_value = r_removed;
    assign o_rsp.status        = r_status;
    assign o_rsp.occupancy     = r_occ;

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A removal from an empty queue reports the empty status next cycle.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_empty && (i_req.mode == MODE_POP_MAX || i_req.mode == MODE_POP_MIN))
        |=> (r_out_valid && r_status == ST_EMPTY && r_removed == '0))
        else $error("empty removal not reported");

    // An add to a full queue leaves the count alone.
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && i_req.mode == MODE_ADD)
        |=> (r_count == $past(r_count) && r_status == ST_FULL))
        else $error("add to full queue changed the count");

    // A nonzero removed value only comes with an ok status.
    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_removed != '0) |-> (r_status == ST_OK))
        else $error("removed value with failure status");

    // The two lowest occupied cells stay in ascending order.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_cell_val[0] <= w_cell_val[1]))
        else $error("chain out of order");

endmodule

// File: tb/double_ended_priority_queue_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_priority_queue: a directed table, then random requests,
// with every result checked against a sorted-list predictor kept in the testbench or a typed table row.
// Depends on dep_pkg, dep_in_if, dep_out_if and the double_ended_priority_queue RTL.
module double_ended_priority_queue_tb
    import dep_pkg::*;
;

    // The fourth code of the mode field has no name in the package.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RAND_ITEMS       = 850;
    localparam int QUIET_TAIL       = 100;
    localparam int SEGMENT_LEN      = 40;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int LONG_HOLD_AT     = 200;
    localparam int SENDER_PAUSE_AT  = 450;
    localparam int DRAIN_CYCLES     = 8;
    localparam int MAX_REPORTS      = 10;
    localparam int N_DIR_ROWS       = 12;
    localparam int WATCHDOG_NS      = 2_000_000;

    localparam logic signed [DEP_VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DEP_VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DEP_VAL_W-1:0] removed_value;
        logic [1:0]                  status;
        logic [DEP_OCC_W-1:0]        occupancy;
    } t_dep_result;

    // One row of the directed table; a row may repeat its request several times.
    typedef struct packed {
        logic [1:0]                  mode;
        logic signed [DEP_VAL_W-1:0] value;
        logic [4:0]                  reps;
        logic                        typed;
        t_dep_result                 want;
    } t_stim_row;

    localparam t_dep_result NO_WANT = '0;

    // Empty removals, the unused code, both extremes, duplicates and a full queue.
    localparam t_stim_row DIR_ROWS [N_DIR_ROWS] = '{
        '{MODE_POP_MAX, 32'sd0,   5'd1,  1'b1, '{32'sd0,  ST_EMPTY, 5'd0}},
        '{MODE_POP_MIN, VAL_MAX,  5'd1,  1'b1, '{32'sd0,  ST_EMPTY, 5'd0}},
        '{MODE_UNUSED,  -32'sd1,  5'd1,  1'b1, '{32'sd0,  ST_OK,    5'd0}},
        '{MODE_ADD,     VAL_MAX,  5'd1,  1'b1, '{32'sd0,  ST_OK,    5'd1}},
        '{MODE_ADD,     VAL_MIN,  5'd1,  1'b1, '{32'sd0,  ST_OK,    5'd2}},
        '{MODE_ADD,     -32'sd1,  5'd2,  1'b0, NO_WANT},
        '{MODE_POP_MAX, 32'sd0,   5'd1,  1'b1, '{VAL_MAX, ST_OK,    5'd3}},
        '{MODE_POP_MIN, 32'sd0,   5'd1,  1'b1, '{VAL_MIN, ST_OK,    5'd2}},
        '{MODE_ADD,     32'sd0,   5'd14, 1'b0, NO_WANT},
        '{MODE_ADD,     32'sd1,   5'd1,  1'b1, '{32'sd0,  ST_FULL,  5'd16}},
        '{MODE_POP_MIN, 32'sd0,   5'd1,  1'b0, NO_WANT},
        '{MODE_POP_MAX, 32'sd0,   5'd1,  1'b0, NO_WANT}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dep_in_if  req_if ();
    dep_out_if rsp_if ();

    // Typed expectation that travels alongside the request being offered.
    logic        req_typed = 1'b0;
    t_dep_result req_want  = '0;

    bit rx_idle_en    = 1'b0;
    bit long_hold_req = 1'b0;

    // Values held by the queue, ascending, and results still to arrive.
    logic signed [DEP_VAL_W-1:0] held_values[$];
    t_dep_result                 awaited_results[$];

    int mismatches      = 0;
    int results_checked = 0;
    int add_count       = 0;
    int max_count       = 0;
    int min_count       = 0;
    int unused_count    = 0;
    int full_count      = 0;
    int empty_count     = 0;

    double_ended_priority_queue dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    // Applies one request to the held values and returns the result it should give.
    function automatic t_dep_result apply_request(input logic [1:0] mode,
                                                  input logic signed [DEP_VAL_W-1:0] value);
        t_dep_result res;
        int          pos;
        res = '0;
        res.status = ST_OK;
        case (mode)
            MODE_ADD: begin
                if (held_values.size() >= DEP_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    pos = held_values.size();
                    while (pos > 0 && value < held_values[pos-1]) pos--;
                    held_values.insert(pos, value);
                end
            end
            MODE_POP_MAX: begin
                if (held_values.size() == 0) res.status = ST_EMPTY;
                else res.removed_value = held_values.pop_back();
            end
            MODE_POP_MIN: begin
                if (held_values.size() == 0) res.status = ST_EMPTY;
                else res.removed_value = held_values.pop_front();
            end
            default: ;
        endcase
        res.occupancy = DEP_OCC_W'(held_values.size());
        return res;
    endfunction

    function automatic void report_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(input logic [1:0] mode, input logic signed [DEP_VAL_W-1:0] value,
                                input logic typed, input t_dep_result want);
        req_if.valid <= 1'b1;
        req_if.mode  <= mode;
        req_if.value <= value;
        req_typed    <= typed;
        req_want     <= want;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // Predicts on each accepted request, then checks each accepted result.
    always @(posedge clk) begin : monitor
        t_dep_result exp_res;
        t_dep_result got_res;
        if (rst_n) begin
            if (req_if.valid && req_if.ready) begin
                exp_res = apply_request(req_if.mode, req_if.value);
                if (req_typed) exp_res = req_want;
                awaited_results.push_back(exp_res);
                case (req_if.mode)
                    MODE_ADD:     add_count++;
                    MODE_POP_MAX: max_count++;
                    MODE_POP_MIN: min_count++;
                    default:      unused_count++;
                endcase
                if (exp_res.status == ST_FULL) full_count++;
                if (exp_res.status == ST_EMPTY) empty_count++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got_res.removed_value = rsp_if.removed_value;
                got_res.status        = rsp_if.status;
                got_res.occupancy     = rsp_if.occupancy;
                if (awaited_results.size() == 0) begin
                    report_failure($sformatf("result with none awaited: value %0d status %0d occ %0d",
                                             got_res.removed_value, got_res.status,
                                             got_res.occupancy));
                end else begin
                    exp_res = awaited_results.pop_front();
                    results_checked++;
                    if (got_res.removed_value !== exp_res.removed_value ||
                        got_res.status !== exp_res.status ||
                        got_res.occupancy !== exp_res.occupancy) begin
                        report_failure($sformatf(
                            "result %0d: expected value %0d status %0d occ %0d, got %0d %0d %0d",
                            results_checked, exp_res.removed_value, exp_res.status,
                            exp_res.occupancy, got_res.removed_value, got_res.status,
                            got_res.occupancy));
                    end
                end
            end
        end
    end

    // Result side: ready in random bursts, plus one long hold-off on request.
    initial begin : receiver
        forever begin
            if (long_hold_req) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Request side: reset, the directed table, then random segments.
    initial begin : sender
        int                          add_pct;
        int                          val_style;
        int                          pick;
        bit                          seg_idle;
        logic [1:0]                  m;
        logic signed [DEP_VAL_W-1:0] v;
        add_pct   = 50;
        val_style = 0;
        seg_idle  = 1'b0;
        req_if.valid <= 1'b0;
        req_if.mode  <= MODE_ADD;
        req_if.value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_DIR_ROWS; r++) begin
            for (int k = 0; k < DIR_ROWS[r].reps; k++) begin
                send_request(DIR_ROWS[r].mode, DIR_ROWS[r].value, DIR_ROWS[r].typed,
                             DIR_ROWS[r].want);
            end
        end

        for (int i = 0; i < RAND_ITEMS; i++) begin
            // Each segment leans toward filling or draining the queue, or keeps adds and removals even.
            if (i % SEGMENT_LEN == 0) begin
                case ($urandom_range(0, 3))
                    0:       add_pct = 25;
                    1:       add_pct = 50;
                    2:       add_pct = 75;
                    default: add_pct = 95;
                endcase
                val_style  = $urandom_range(0, 2);
                seg_idle   = (i < RAND_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
                rx_idle_en = seg_idle;
            end
            if (i == LONG_HOLD_AT) long_hold_req = 1'b1;

            // Either wait for the queue of results to empty, or idle for a short burst.
            if (i == SENDER_PAUSE_AT) begin
                req_if.valid <= 1'b0;
                do @(posedge clk); while (awaited_results.size() != 0);
            end else if (seg_idle && $urandom_range(0, 4) == 0) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end

            pick = $urandom_range(0, 99);
            if (pick < 3) m = MODE_UNUSED;
            else if (pick < add_pct) m = MODE_ADD;
            else if ($urandom_range(0, 1) == 0) m = MODE_POP_MAX;
            else m = MODE_POP_MIN;

            // Narrow values give many duplicates; the last style favors the extremes.
            case (val_style)
                0:       v = $urandom;
                1:       v = $urandom_range(0, 7) - 4;
                default: begin
                    case ($urandom_range(0, 4))
                        0:       v = VAL_MAX;
                        1:       v = VAL_MIN;
                        2:       v = '0;
                        3:       v = -32'sd1;
                        default: v = $urandom;
                    endcase
                end
            endcase
            send_request(m, v, 1'b0, NO_WANT);
        end

        req_if.valid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests: %0d adds, %0d max and %0d min removals, %0d unused.",
                 add_count + max_count + min_count + unused_count, add_count, max_count,
                 min_count, unused_count);
        $display("%0d results checked, %0d full and %0d empty statuses, %0d mismatches.",
                 results_checked, full_count, empty_count, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("double_ended_priority_queue_tb: PASS");
        end else begin
            $display("double_ended_priority_queue_tb: FAIL");
        end
        $finish;
    end

    // Ends a hung run.
    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("Timeout with %0d results still awaited.", awaited_results.size());
        $display("double_ended_priority_queue_tb: FAIL");
        $finish;
    end

endmodule
